@@ rtl/fvng_pkg.sv @@
// ----------------------------------------------------------------------------
// fvng_pkg: shared types and constants of the four-voice note gate trigger
// Request and note formats, command and source codes, register reset values.
// ----------------------------------------------------------------------------
package fvng_pkg;

	localparam int VOICE_COUNT_DEF = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;

	localparam logic [7:0] NO_PITCH = 8'hFF;

	localparam logic [7:0]  RST_SOURCES   = 8'd0;
	localparam logic [31:0] RST_PERIOD    = 32'd3072000;
	localparam logic [12:0] RST_BLOCK_LEN = 13'd512;
	localparam logic [15:0] RST_JOY_THR   = 16'd3277;
	localparam logic [16:0] RST_DENSITY   = 17'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCES   = 3'd0,
		CFG_PERIOD    = 3'd1,
		CFG_BLOCK_LEN = 3'd2,
		CFG_JOY_THR   = 3'd3,
		CFG_DENSITY   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_PAD      = 2'd0,
		CMD_TRIG_ALL = 2'd1,
		CMD_BLOCK    = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SRC_PAD  = 2'd0,
		SRC_JOY  = 2'd1,
		SRC_RND  = 2'd2,
		SRC_NONE = 2'd3
	} src_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [1:0]         voice;
		logic               pad_down;
		logic signed [15:0] joy_x;
		logic signed [15:0] joy_y;
		logic [31:0]        held_pitches;
		logic [63:0]        random_draws;
	} gate_req_t;

	typedef struct packed {
		logic [1:0] note_voice;
		logic [6:0] note_pitch;
		logic       note_is_on;
		logic       last_event;
	} note_t;

	// per-voice context handed to the voice evaluator
	typedef struct packed {
		src_t        src;
		logic [7:0]  held;
		logic [15:0] draw;
		logic        pad_held;
	} voice_ctx_t;

	typedef struct packed {
		logic       gate;
		logic [7:0] sound;
		logic [7:0] joyp;
		logic       pad_rising;
	} voice_st_t;

	typedef struct packed {
		logic        all;
		logic        moved;
		logic        fired;
		logic [16:0] density;
	} blk_ctl_t;

	typedef struct packed {
		logic       valid;
		logic [6:0] pitch;
		logic       is_on;
	} voice_ev_t;

	typedef struct packed {
		voice_ev_t e0;
		voice_ev_t e1;
	} voice_evt_t;

endpackage

@@ rtl/fvng_mod_unit.sv @@
// ----------------------------------------------------------------------------
// fvng_mod_unit: bit-serial remainder unit
// Restoring remainder of a 33-bit dividend by a 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module fvng_mod_unit import fvng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] rem
);

	localparam int STEPS = 33;
	localparam int CNT_W = $clog2(STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [32:0]      dvd_q;
	logic [31:0]      rem_q;
	logic [32:0]      trial;
	logic [32:0]      diff;
	logic             ge;

	// shift in the next dividend bit, subtract when the partial remainder fits
	assign trial = {rem_q, dvd_q[32]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			dvd_q <= {dvd_q[31:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ rtl/fvng_voice_eval.sv @@
// ----------------------------------------------------------------------------
// fvng_voice_eval: gate decision for one voice
// Picks the voice's source action and yields its next state and up to two events.
// ----------------------------------------------------------------------------
module fvng_voice_eval import fvng_pkg::*; (
	input  voice_ctx_t ctx,
	input  voice_st_t  cur,
	input  blk_ctl_t   blk,
	output voice_st_t  nxt,
	output voice_evt_t evt
);

	logic trig;
	logic held_ok;
	logic sound_ok;
	logic joyp_ok;

	assign held_ok  = !ctx.held[7];
	assign sound_ok = !cur.sound[7];
	assign joyp_ok  = !cur.joyp[7];

	always_comb begin
		nxt  = cur;
		evt  = '0;
		trig = 1'b0;
		if (blk.all) begin
			trig = 1'b1;
		end else begin
			case (ctx.src)
				SRC_PAD: begin
					nxt.pad_rising = 1'b0;
					if (cur.pad_rising) begin
						trig = 1'b1;
					end else if (!ctx.pad_held && cur.gate && sound_ok) begin
						evt.e0   = '{valid: 1'b1, pitch: cur.sound[6:0], is_on: 1'b0};
						nxt.gate  = 1'b0;
						nxt.sound = NO_PITCH;
					end
				end
				SRC_JOY: begin
					if (blk.moved) begin
						if (!cur.gate) begin
							if (held_ok) begin
								evt.e0    = '{valid: 1'b1, pitch: ctx.held[6:0], is_on: 1'b1};
								nxt.gate  = 1'b1;
								nxt.sound = ctx.held;
							end
							nxt.joyp = ctx.held;
						end else if (ctx.held != cur.joyp) begin
							// legato: new note on before the old note off
							if (held_ok) begin
								evt.e0    = '{valid: 1'b1, pitch: ctx.held[6:0], is_on: 1'b1};
								nxt.gate  = 1'b1;
								nxt.sound = ctx.held;
							end
							if (joyp_ok) begin
								evt.e1 = '{valid: 1'b1, pitch: cur.joyp[6:0], is_on: 1'b0};
							end
							nxt.joyp = ctx.held;
						end
					end
				end
				SRC_RND: begin
					if (blk.fired && ({1'b0, ctx.draw} < blk.density)) begin
						trig = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (trig) begin
			if (cur.gate && sound_ok) begin
				evt.e0    = '{valid: 1'b1, pitch: cur.sound[6:0], is_on: 1'b0};
				nxt.gate  = 1'b0;
				nxt.sound = NO_PITCH;
			end
			if (held_ok) begin
				evt.e1    = '{valid: 1'b1, pitch: ctx.held[6:0], is_on: 1'b1};
				nxt.gate  = 1'b1;
				nxt.sound = ctx.held;
			end
		end
	end

endmodule

@@ rtl/four_voice_note_gate_trigger_core.sv @@
// ----------------------------------------------------------------------------
// four_voice_note_gate_trigger_core: four-voice note gate controller
// Pad, joystick and random-clock gates per voice, emitting note on/off events.
// ----------------------------------------------------------------------------
// Pad change, trigger all and clear gates are taken in idle, the only state
// in which requests are ready. A block runs the joystick and check states,
// waits on the bit-serial remainder unit when the random clock wraps, then
// each voice; its events leave a buffer at one per cycle unless output stalls.
// Reset (arst_n low) clears gates, pitches, pad state, phase, joystick history
// and loads the register defaults.
module four_voice_note_gate_trigger_core import fvng_pkg::*; #(
	parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  gate_req_t             req,
	output logic                  note_valid,
	input  logic                  note_ready,
	output note_t                 note
);

	localparam int VW       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int VXW      = VW + 2;
	localparam int EV_DEPTH = 2 * VOICE_COUNT;
	localparam int IW       = $clog2(EV_DEPTH);
	localparam int CW       = $clog2(EV_DEPTH + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_JOY   = 6'b000010,
		ST_CHK   = 6'b000100,
		ST_MOD   = 6'b001000,
		ST_VOICE = 6'b010000,
		ST_DRAIN = 6'b100000
	} state_t;

	state_t state_q;

	logic [7:0]  sources_q;
	logic [31:0] period_q;
	logic [12:0] block_len_q;
	logic [15:0] joy_thr_q;
	logic [16:0] density_q;

	logic [VOICE_COUNT-1:0] gate_q;
	logic [VOICE_COUNT-1:0] pad_held_q;
	logic [VOICE_COUNT-1:0] pad_rising_q;
	logic [7:0]             sound_q [VOICE_COUNT];
	logic [7:0]             joyp_q  [VOICE_COUNT];
	logic                   pend_q;
	logic [31:0]            phase_q;
	logic signed [15:0]     prev_x_q;
	logic signed [15:0]     prev_y_q;

	logic               all_q;
	logic               moved_q;
	logic               fired_q;
	logic [VW-1:0]      vi_q;
	logic [CW-1:0]      ev_cnt_q;
	logic [CW-1:0]      rd_q;
	logic               note_valid_q;

	logic signed [15:0] jx_q;
	logic signed [15:0] jy_q;
	logic [31:0]        pitches_q;
	logic [63:0]        draws_q;
	logic [32:0]        sum_q;
	note_t              evbuf_q [EV_DEPTH];
	note_t              note_q;

	logic               req_acc;
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [16:0]        ax;
	logic [16:0]        ay;
	logic [16:0]        mag;
	logic               fire;
	logic               mod_start;
	logic               mod_done;
	logic [31:0]        mod_rem;

	logic [VXW-1:0] vx;
	logic [1:0]     lane;
	logic           in_range;
	logic [7:0]     raw_pitch;
	voice_ctx_t     ctx;
	voice_st_t      cur;
	voice_st_t      nxt;
	blk_ctl_t       blk;
	voice_evt_t     evt;
	logic [CW-1:0]  cnt_nxt;
	logic [IW-1:0]  idx0;
	logic [IW-1:0]  idx1;
	logic           last_voice;
	logic [CW-1:0]  rd_inc;
	logic           load;
	note_t          rd_note;
	logic [VOICE_COUNT-1:0] sound_ok;

	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;

	// joystick: Chebyshev distance against the previous position
	assign dx  = {jx_q[15], jx_q} - {prev_x_q[15], prev_x_q};
	assign dy  = {jy_q[15], jy_q} - {prev_y_q[15], prev_y_q};
	assign ax  = dx[16] ? 17'(-dx) : 17'(dx);
	assign ay  = dy[16] ? 17'(-dy) : 17'(dy);
	assign mag = (ax > ay) ? ax : ay;

	assign fire      = (period_q != '0) && (sum_q >= {1'b0, period_q});
	assign mod_start = (state_q == ST_CHK) && fire;

	fvng_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (sum_q),
		.divisor  (period_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// voice context at the current voice index
	assign vx        = VXW'(vi_q);
	assign lane      = vx[1:0];
	assign in_range  = vx < VXW'(4);
	assign raw_pitch = pitches_q[{lane, 3'b000} +: 8];

	always_comb begin
		ctx.src      = in_range ? src_t'(sources_q[{lane, 1'b0} +: 2]) : SRC_NONE;
		ctx.held     = (in_range && !raw_pitch[7]) ? raw_pitch : NO_PITCH;
		ctx.draw     = draws_q[{lane, 4'b0000} +: 16];
		ctx.pad_held = pad_held_q[vi_q];
		cur.gate       = gate_q[vi_q];
		cur.sound      = sound_q[vi_q];
		cur.joyp       = joyp_q[vi_q];
		cur.pad_rising = pad_rising_q[vi_q];
		blk.all     = all_q;
		blk.moved   = moved_q;
		blk.fired   = fired_q;
		blk.density = density_q;
	end

	fvng_voice_eval u_voice (
		.ctx (ctx),
		.cur (cur),
		.blk (blk),
		.nxt (nxt),
		.evt (evt)
	);

	assign cnt_nxt    = ev_cnt_q + CW'(evt.e0.valid) + CW'(evt.e1.valid);
	assign idx0       = ev_cnt_q[IW-1:0];
	assign idx1       = IW'(ev_cnt_q + 1'b1);
	assign last_voice = (vi_q == VW'(VOICE_COUNT - 1));
	assign rd_inc     = CW'(rd_q + 1'b1);
	assign load       = (state_q == ST_DRAIN) && (rd_q != ev_cnt_q)
	                    && (!note_valid_q || note_ready);
	assign rd_note    = evbuf_q[rd_q[IW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sources_q    <= RST_SOURCES;
			period_q     <= RST_PERIOD;
			block_len_q  <= RST_BLOCK_LEN;
			joy_thr_q    <= RST_JOY_THR;
			density_q    <= RST_DENSITY;
			gate_q       <= '0;
			pad_held_q   <= '0;
			pad_rising_q <= '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				sound_q[v] <= NO_PITCH;
				joyp_q[v]  <= NO_PITCH;
			end
			pend_q       <= 1'b0;
			phase_q      <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			all_q        <= 1'b0;
			moved_q      <= 1'b0;
			fired_q      <= 1'b0;
			vi_q         <= '0;
			ev_cnt_q     <= '0;
			rd_q         <= '0;
			note_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SOURCES:   sources_q   <= cfg_data[7:0];
					CFG_PERIOD:    period_q    <= cfg_data[31:0];
					CFG_BLOCK_LEN: block_len_q <= cfg_data[12:0];
					CFG_JOY_THR:   joy_thr_q   <= cfg_data[15:0];
					CFG_DENSITY:   density_q   <= cfg_data[16:0];
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						case (cmd_t'(req.cmd))
							CMD_PAD: begin
								// latch the rising edge until a block consumes it on a pad voice
								for (int v = 0; v < VOICE_COUNT; v++) begin
									if (int'(req.voice) == v) begin
										pad_held_q[v] <= req.pad_down;
										if (req.pad_down && !pad_held_q[v]) begin
											pad_rising_q[v] <= 1'b1;
										end
									end
								end
							end
							CMD_TRIG_ALL: pend_q <= 1'b1;
							CMD_BLOCK: state_q <= ST_JOY;
							CMD_CLEAR: begin
								gate_q       <= '0;
								pad_held_q   <= '0;
								pad_rising_q <= '0;
								for (int v = 0; v < VOICE_COUNT; v++) begin
									sound_q[v] <= NO_PITCH;
									joyp_q[v]  <= NO_PITCH;
								end
								pend_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_JOY: begin
					moved_q  <= mag > {1'b0, joy_thr_q};
					prev_x_q <= jx_q;
					prev_y_q <= jy_q;
					all_q    <= pend_q;
					pend_q   <= 1'b0;
					state_q  <= ST_CHK;
				end
				ST_CHK: begin
					fired_q  <= fire;
					vi_q     <= '0;
					ev_cnt_q <= '0;
					if (fire) begin
						state_q <= ST_MOD;
					end else begin
						phase_q <= sum_q[31:0];
						state_q <= ST_VOICE;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						phase_q <= mod_rem;
						state_q <= ST_VOICE;
					end
				end
				ST_VOICE: begin
					for (int v = 0; v < VOICE_COUNT; v++) begin
						if (int'(vi_q) == v) begin
							gate_q[v]       <= nxt.gate;
							sound_q[v]      <= nxt.sound;
							joyp_q[v]       <= nxt.joyp;
							pad_rising_q[v] <= nxt.pad_rising;
						end
					end
					ev_cnt_q <= cnt_nxt;
					if (last_voice) begin
						rd_q    <= '0;
						state_q <= (cnt_nxt == '0) ? ST_IDLE : ST_DRAIN;
					end else begin
						vi_q <= vi_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (load) begin
						rd_q <= rd_inc;
						if (rd_inc == ev_cnt_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load) begin
				note_valid_q <= 1'b1;
			end else if (note_ready) begin
				note_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			jx_q      <= req.joy_x;
			jy_q      <= req.joy_y;
			pitches_q <= req.held_pitches;
			draws_q   <= req.random_draws;
		end
		if (state_q == ST_JOY) begin
			sum_q <= {1'b0, phase_q} + 33'({block_len_q, 8'h00});
		end
		if (state_q == ST_VOICE) begin
			if (evt.e0.valid) begin
				evbuf_q[idx0] <= '{note_voice: lane, note_pitch: evt.e0.pitch,
				                   note_is_on: evt.e0.is_on, last_event: 1'b0};
			end
			if (evt.e1.valid) begin
				evbuf_q[evt.e0.valid ? idx1 : idx0] <= '{note_voice: lane,
				                   note_pitch: evt.e1.pitch,
				                   note_is_on: evt.e1.is_on, last_event: 1'b0};
			end
		end
		if (load) begin
			note_q <= '{note_voice: rd_note.note_voice, note_pitch: rd_note.note_pitch,
			            note_is_on: rd_note.note_is_on, last_event: (rd_inc == ev_cnt_q)};
		end
	end

	assign note_valid = note_valid_q;
	assign note       = note_q;

	for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_sound_ok
		assign sound_ok[g] = !sound_q[g][7];
	end

	a_ev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ev_cnt_q <= CW'(EV_DEPTH))
		else $error("event count exceeds buffer depth");

	a_drain_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (rd_q < ev_cnt_q))
		else $error("drain pointer past event count");

	a_gate_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		gate_q == sound_ok)
		else $error("open gate without sounding pitch");

	a_mod_done: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MOD))
		else $error("remainder done outside its wait state");

endmodule

@@ dv/tb_four_voice_note_gate_trigger_core.sv @@
// ----------------------------------------------------------------------------
// tb_four_voice_note_gate_trigger_core: self-checking bench for the note gate
// A short directed walk through pads, trigger all, joystick legato, the random
// clock and gate clearing, then random traffic over several register settings.
// Each output note is checked against an in-bench gate predictor or a typed note.
// ----------------------------------------------------------------------------
module tb_four_voice_note_gate_trigger_core;
	import fvng_pkg::*;

	localparam int NV              = VOICE_COUNT_DEF;
	localparam int IDLE_SETTLE     = 48;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 4000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 48;
	localparam logic [31:0] PITCH_SET = 32'h7F80_003C;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_ready;
	gate_req_t             req;
	logic                  note_valid;
	logic                  note_ready;
	note_t                 note;

	four_voice_note_gate_trigger_core #(.VOICE_COUNT(NV)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.note_valid(note_valid),
		.note_ready(note_ready),
		.note      (note)
	);

	typedef struct {
		bit         is_cfg;
		cfg_idx_t   idx;
		logic [31:0] data;
		gate_req_t  r;
		int         typed_n;   // -1: predictor decides
		note_t      typed_note;
	} stim_row_t;

	// predictor state and register copy
	logic        gate_m     [NV];
	logic [7:0]  sound_m    [NV];
	logic [7:0]  joyp_m     [NV];
	logic        pad_held_m [NV];
	logic        pad_rise_m [NV];
	logic        trig_pend_m;
	logic [31:0] phase_m;
	logic signed [15:0] prev_x_m;
	logic signed [15:0] prev_y_m;
	logic [7:0]  sources_r;
	logic [31:0] period_r;
	logic [12:0] blen_r;
	logic [15:0] thr_r;
	logic [16:0] density_r;

	note_t     block_notes[$];
	note_t     expected_notes[$];
	stim_row_t dir_rows[$];
	logic [31:0] last_pitches;

	int  burst_left;
	int  mismatches;
	int  notes_checked;
	int  requests_sent;
	int  blocks_sent;
	int  regs_written;
	int  holds_done;
	bit  hold_notes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic note_t mk_note(int v, logic [7:0] p, bit on, bit last);
		note_t n;
		n.note_voice = v[1:0];
		n.note_pitch = p[6:0];
		n.note_is_on = on;
		n.last_event = last;
		return n;
	endfunction

	task automatic clear_gates_m();
		for (int v = 0; v < NV; v++) begin
			gate_m[v]     = 1'b0;
			sound_m[v]    = NO_PITCH;
			joyp_m[v]     = NO_PITCH;
			pad_held_m[v] = 1'b0;
			pad_rise_m[v] = 1'b0;
		end
		trig_pend_m = 1'b0;
	endtask

	task automatic apply_reg(input cfg_idx_t idx, input logic [31:0] d);
		case (idx)
			CFG_SOURCES:   sources_r = d[7:0];
			CFG_PERIOD:    period_r  = d;
			CFG_BLOCK_LEN: blen_r    = d[12:0];
			CFG_JOY_THR:   thr_r     = d[15:0];
			CFG_DENSITY:   density_r = d[16:0];
			default: ;
		endcase
	endtask

	task automatic note_on_m(input int v, input logic [7:0] p);
		if (p <= 8'd127) begin
			sound_m[v] = p;
			gate_m[v]  = 1'b1;
			block_notes.push_back(mk_note(v, p, 1'b1, 1'b0));
		end
	endtask

	task automatic note_off_m(input int v);
		logic [7:0] p;
		p = sound_m[v];
		if (p <= 8'd127) begin
			gate_m[v]  = 1'b0;
			sound_m[v] = NO_PITCH;
			block_notes.push_back(mk_note(v, p, 1'b0, 1'b0));
		end
	endtask

	// Work out the notes one accepted request causes and advance the state.
	task automatic predict_notes(input gate_req_t r);
		int dx, dy, ax, ay, mag;
		bit moved, every, fired, trig;
		logic [63:0] ph;
		logic [1:0] src;
		logic [7:0] held, prev_jp;
		logic [15:0] draw;
		block_notes.delete();
		case (r.cmd)
			CMD_PAD: begin
				if (r.pad_down && !pad_held_m[r.voice])
					pad_rise_m[r.voice] = 1'b1;
				pad_held_m[r.voice] = r.pad_down;
			end
			CMD_TRIG_ALL: trig_pend_m = 1'b1;
			CMD_CLEAR: clear_gates_m();
			default: begin
				dx = int'($signed(r.joy_x)) - int'(prev_x_m);
				dy = int'($signed(r.joy_y)) - int'(prev_y_m);
				ax = dx < 0 ? -dx : dx;
				ay = dy < 0 ? -dy : dy;
				mag = ax > ay ? ax : ay;
				moved = mag > int'(thr_r);
				prev_x_m = r.joy_x;
				prev_y_m = r.joy_y;
				every = trig_pend_m;
				trig_pend_m = 1'b0;
				ph = {32'd0, phase_m} + ({51'd0, blen_r} << 8);
				fired = 1'b0;
				if (period_r != 32'd0 && ph >= {32'd0, period_r}) begin
					ph = ph % {32'd0, period_r};
					fired = 1'b1;
				end
				phase_m = ph[31:0];
				for (int v = 0; v < NV; v++) begin
					src  = sources_r[2*v +: 2];
					held = r.held_pitches[8*v +: 8];
					if (held > 8'd127)
						held = NO_PITCH;
					draw = r.random_draws[16*v +: 16];
					trig = 1'b0;
					if (every) begin
						trig = 1'b1;
					end else begin
						case (src)
							SRC_PAD: begin
								if (pad_rise_m[v]) begin
									pad_rise_m[v] = 1'b0;
									trig = 1'b1;
								end else if (!pad_held_m[v] && gate_m[v]) begin
									note_off_m(v);
								end
							end
							SRC_JOY: begin
								if (moved && !gate_m[v]) begin
									note_on_m(v, held);
									joyp_m[v] = held;
								end else if (moved && held != joyp_m[v]) begin
									// legato: new note first, then release the old one
									prev_jp = joyp_m[v];
									note_on_m(v, held);
									if (prev_jp <= 8'd127)
										block_notes.push_back(mk_note(v, prev_jp, 1'b0, 1'b0));
									joyp_m[v] = held;
								end
							end
							SRC_RND: begin
								if (fired && {1'b0, draw} < density_r)
									trig = 1'b1;
							end
							default: ;
						endcase
					end
					if (trig) begin
						if (gate_m[v])
							note_off_m(v);
						note_on_m(v, held);
					end
				end
				if (block_notes.size() > 0)
					block_notes[block_notes.size()-1].last_event = 1'b1;
			end
		endcase
	endtask

	function automatic stim_row_t req_row(cmd_t c, int vc, bit down, int jx, int jy,
			logic [31:0] p, logic [63:0] d);
		stim_row_t rw;
		rw.is_cfg         = 1'b0;
		rw.idx            = CFG_SOURCES;
		rw.data           = '0;
		rw.r.cmd          = c;
		rw.r.voice        = vc[1:0];
		rw.r.pad_down     = down;
		rw.r.joy_x        = jx[15:0];
		rw.r.joy_y        = jy[15:0];
		rw.r.held_pitches = p;
		rw.r.random_draws = d;
		rw.typed_n        = -1;
		rw.typed_note     = '0;
		return rw;
	endfunction

	function automatic stim_row_t cfg_row(cfg_idx_t i, logic [31:0] d);
		stim_row_t rw;
		rw = req_row(CMD_PAD, 0, 1'b0, 0, 0, '0, '0);
		rw.is_cfg = 1'b1;
		rw.idx    = i;
		rw.data   = d;
		return rw;
	endfunction

	function automatic stim_row_t with_note(stim_row_t rw, int n, note_t nt);
		rw.typed_n    = n;
		rw.typed_note = nt;
		return rw;
	endfunction

	function automatic gate_req_t rand_request();
		gate_req_t r;
		int pick, mode;
		r.cmd          = CMD_PAD;
		r.voice        = 2'($urandom_range(0, 3));
		r.pad_down     = 1'($urandom_range(0, 1));
		r.joy_x        = 16'($urandom);
		r.joy_y        = 16'($urandom);
		r.held_pitches = $urandom;
		r.random_draws = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			r.cmd = CMD_BLOCK;
			mode = $urandom_range(0, 9);
			if (mode < 4) begin
				r.joy_x = prev_x_m;
				r.joy_y = prev_y_m;
			end else if (mode < 8) begin
				r.joy_x = 16'(int'(prev_x_m) + int'($urandom_range(0, 16000)) - 8000);
				r.joy_y = 16'(int'(prev_y_m) + int'($urandom_range(0, 16000)) - 8000);
			end
			mode = $urandom_range(0, 9);
			if (mode < 3) begin
				r.held_pitches = last_pitches;
			end else if (mode > 3) begin
				for (int b = 0; b < 4; b++)
					r.held_pitches[8*b +: 8] = ($urandom_range(0, 99) < 85) ?
						8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
			end
			last_pitches = r.held_pitches;
		end else if (pick < 80) begin
			r.cmd = CMD_PAD;
		end else if (pick < 92) begin
			r.cmd = CMD_TRIG_ALL;
		end else begin
			r.cmd = CMD_CLEAR;
		end
		return r;
	endfunction

	// Offer one request in bursts with random gaps; leave valid high on return.
	task automatic send_req(input gate_req_t r, input int typed_n, input note_t typed_note);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		burst_left--;
		requests_sent++;
		if (r.cmd == CMD_BLOCK)
			blocks_sent++;
		predict_notes(r);
		if (typed_n < 0) begin
			foreach (block_notes[i])
				expected_notes.push_back(block_notes[i]);
		end else if (typed_n > 0) begin
			expected_notes.push_back(typed_note);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, d);
		regs_written++;
		@(negedge clk);
	endtask

	// Drop the request line and wait until the block has gone quiet.
	task automatic wait_drain();
		req_valid <= 1'b0;
		while (expected_notes.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin : note_sink
		int mode, left;
		note_ready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_notes) begin
				// hold off long enough for the block to back up into its input
				note_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_notes = 1'b0;
				holds_done++;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(4, 60);
				end
				left--;
				case (mode)
					0: note_ready <= 1'b1;
					1: note_ready <= 1'($urandom_range(0, 1));
					default: note_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : note_check
		note_t want;
		if (arst_n && note_valid && note_ready) begin
			if (expected_notes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected note at %0t: voice %0d pitch %0d on %0b last %0b",
						$time, note.note_voice, note.note_pitch, note.note_is_on,
						note.last_event);
			end else begin
				want = expected_notes.pop_front();
				notes_checked++;
				if (note.note_voice !== want.note_voice || note.note_pitch !== want.note_pitch
						|| note.note_is_on !== want.note_is_on
						|| note.last_event !== want.last_event) begin
					mismatches++;
					if (mismatches <= 10)
						$display("note mismatch at %0t: expected v%0d p%0d on%0b last%0b, got v%0d p%0d on%0b last%0b",
							$time, want.note_voice, want.note_pitch, want.note_is_on,
							want.last_event, note.note_voice, note.note_pitch,
							note.note_is_on, note.last_event);
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && req_ready) || (cfg_valid && cfg_ready)
					|| (note_valid && note_ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		bit prev_cfg;
		int blen, mode;
		logic [31:0] period;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		req_valid   = 1'b0;
		req         = '0;
		hold_notes  = 1'b0;
		burst_left  = 0;
		mismatches  = 0;
		notes_checked = 0;
		requests_sent = 0;
		blocks_sent   = 0;
		regs_written  = 0;
		holds_done    = 0;
		last_pitches  = PITCH_SET;
		sources_r = RST_SOURCES;
		period_r  = RST_PERIOD;
		blen_r    = RST_BLOCK_LEN;
		thr_r     = RST_JOY_THR;
		density_r = RST_DENSITY;
		clear_gates_m();
		phase_m  = '0;
		prev_x_m = '0;
		prev_y_m = '0;

		// pads on reset defaults
		dir_rows.push_back(with_note(req_row(CMD_BLOCK, 0, 0, 0, 0, '0, '0), 0, '0));
		dir_rows.push_back(req_row(CMD_PAD, 0, 1, 0, 0, '0, '0));
		dir_rows.push_back(with_note(req_row(CMD_BLOCK, 0, 0, 0, 0, PITCH_SET, '0), 1,
			mk_note(0, 8'd60, 1'b1, 1'b1)));
		dir_rows.push_back(req_row(CMD_PAD, 0, 0, 0, 0, '0, '0));
		dir_rows.push_back(with_note(req_row(CMD_BLOCK, 0, 0, 0, 0, PITCH_SET, '0), 1,
			mk_note(0, 8'd60, 1'b0, 1'b1)));
		dir_rows.push_back(req_row(CMD_PAD, 1, 1, 0, 0, '0, '0));
		dir_rows.push_back(req_row(CMD_PAD, 2, 1, 0, 0, '0, '0));
		dir_rows.push_back(req_row(CMD_TRIG_ALL, 0, 0, 0, 0, '0, '0));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, 0, 0, PITCH_SET, '0));
		dir_rows.push_back(req_row(CMD_PAD, 1, 0, 0, 0, '0, '0));
		dir_rows.push_back(req_row(CMD_BLOCK, 3, 1, 0, 0, PITCH_SET, '1));
		dir_rows.push_back(req_row(CMD_CLEAR, 0, 0, 0, 0, '0, '0));
		// joystick on every voice, zero threshold, full-scale swings and legato
		dir_rows.push_back(cfg_row(CFG_SOURCES, 32'h55));
		dir_rows.push_back(cfg_row(CFG_JOY_THR, 32'd0));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, 32767, -32768, PITCH_SET, '0));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, -32768, 32767, 32'h017F_FF3D, '0));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, -32768, 32767, 32'h017F_FF3D, '0));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, 0, 0, 32'h017F_053D, '0));
		dir_rows.push_back(cfg_row(CFG_JOY_THR, 32'd65535));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, 32767, 0, PITCH_SET, '0));
		// random clock: disabled period, then always firing, then never passing
		dir_rows.push_back(cfg_row(CFG_SOURCES, 32'hAA));
		dir_rows.push_back(cfg_row(CFG_PERIOD, 32'd0));
		dir_rows.push_back(cfg_row(CFG_DENSITY, 32'd65536));
		dir_rows.push_back(with_note(req_row(CMD_BLOCK, 0, 0, 0, 0, PITCH_SET, '0), 0, '0));
		dir_rows.push_back(cfg_row(CFG_PERIOD, 32'd256));
		dir_rows.push_back(cfg_row(CFG_BLOCK_LEN, 32'd4096));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, 0, 0, PITCH_SET, 64'hFFFF_0000_8000_7FFF));
		dir_rows.push_back(cfg_row(CFG_DENSITY, 32'd0));
		dir_rows.push_back(cfg_row(CFG_PERIOD, 32'hFFFF_FFFF));
		dir_rows.push_back(cfg_row(CFG_BLOCK_LEN, 32'd1));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, 0, 0, PITCH_SET, '0));
		// one voice per source; trigger all also reaches the silent voice
		dir_rows.push_back(cfg_row(CFG_SOURCES, 32'hE4));
		dir_rows.push_back(req_row(CMD_CLEAR, 0, 0, 0, 0, '0, '0));
		dir_rows.push_back(req_row(CMD_PAD, 3, 1, 0, 0, '0, '0));
		dir_rows.push_back(req_row(CMD_TRIG_ALL, 0, 0, 0, 0, '0, '0));
		dir_rows.push_back(req_row(CMD_BLOCK, 0, 0, 0, 0, PITCH_SET, '0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		prev_cfg = 1'b1;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				if (!prev_cfg)
					wait_drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				if (prev_cfg)
					cfg_valid <= 1'b0;
				send_req(dir_rows[i].r, dir_rows[i].typed_n, dir_rows[i].typed_note);
			end
			prev_cfg = dir_rows[i].is_cfg;
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drain();
			// first two settings take the register extremes
			case (ph)
				0: blen = 4096;
				1: blen = 1;
				default: blen = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
					: $urandom_range(1, 4096);
			endcase
			mode = $urandom_range(0, 3);
			if (ph == 0)
				period = 32'd1;
			else if (ph == 1)
				period = 32'hFFFF_FFFF;
			else if (ph == 2)
				period = 32'd0;
			else if (mode == 0)
				period = $urandom;
			else
				period = $urandom_range(1, blen * 256 * 3);
			write_reg(CFG_SOURCES, 32'($urandom_range(0, 255)));
			write_reg(CFG_PERIOD, period);
			write_reg(CFG_BLOCK_LEN, 32'(blen));
			write_reg(CFG_JOY_THR, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd65535
				: 32'($urandom_range(0, 6000)));
			write_reg(CFG_DENSITY, (ph == 0) ? 32'd65536 : (ph == 1) ? 32'd0
				: 32'($urandom_range(0, 65536)));
			cfg_valid <= 1'b0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (ph == 3 && i == 10)
					hold_notes = 1'b1;
				send_req(rand_request(), -1, '0);
			end
		end
		wait_drain();

		$display("Covered %0d requests (%0d blocks) and %0d register writes, %0d long holds.",
			requests_sent, blocks_sent, regs_written, holds_done);
		$display("Checked %0d note events, %0d mismatches.", notes_checked, mismatches);
		if (mismatches == 0 && expected_notes.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
